[hw/rtl/tpq_pkg.sv]
// Shared constants and the control type for the touch press qualifier.
package tpq_pkg;

    localparam int WINDOW_DEF      = 5;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int POINT_BITS      = 12;
    localparam int PRESSURE_BITS   = 16;
    localparam int TIME_BITS       = 32;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PRESSURE_THRESHOLD = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_TIME      = CFG_INDEX_BITS'(1);

    localparam logic [CFG_DATA_BITS-1:0] THRESHOLD_RESET = CFG_DATA_BITS'(50);
    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET  = CFG_DATA_BITS'(50);

    // Per-transaction decision from the press qualifier.
    typedef struct packed {
        logic shift;   // sample enters the window chain
        logic touch;   // report the median point
        logic held;    // pressed state after this sample
    } t_qual_ctrl;

endpackage

[hw/rtl/tpq_cell.sv]
// One window cell: holds an X/Y sample pair, shifts it on, ranks its next value.
module tpq_cell
    import tpq_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int INDEX       = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_shift,
    input  logic [SAMPLE_BITS-1:0]              i_data_x,
    input  logic [SAMPLE_BITS-1:0]              i_data_y,
    input  logic [WINDOW-1:0][SAMPLE_BITS-1:0]  i_next_x,
    input  logic [WINDOW-1:0][SAMPLE_BITS-1:0]  i_next_y,
    output logic [SAMPLE_BITS-1:0]              o_x,
    output logic [SAMPLE_BITS-1:0]              o_y,
    output logic [SAMPLE_BITS-1:0]              o_next_x,
    output logic [SAMPLE_BITS-1:0]              o_next_y,
    output logic                                o_pick_x,
    output logic                                o_pick_y
);

    localparam int RANK_BITS = $clog2(WINDOW);
    localparam logic [SAMPLE_BITS-1:0] MID_VALUE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [RANK_BITS-1:0]   MED_RANK  = RANK_BITS'(WINDOW / 2);

    logic [SAMPLE_BITS-1:0] r_x, r_y;
    logic [RANK_BITS-1:0]   rank_x, rank_y;

    assign o_next_x = i_shift ? i_data_x : r_x;
    assign o_next_y = i_shift ? i_data_y : r_y;
    assign o_x      = r_x;
    assign o_y      = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= MID_VALUE;
            r_y <= MID_VALUE;
        end else begin
            r_x <= o_next_x;
            r_y <= o_next_y;
        end
    end

    // Rank among the next window; equal values break ties by cell position.
    always_comb begin
        rank_x = '0;
        rank_y = '0;
        for (int j = 0; j < WINDOW; j++) begin
            if (j < INDEX) begin
                rank_x = rank_x + RANK_BITS'(i_next_x[j] <= o_next_x);
                rank_y = rank_y + RANK_BITS'(i_next_y[j] <= o_next_y);
            end else if (j > INDEX) begin
                rank_x = rank_x + RANK_BITS'(i_next_x[j] < o_next_x);
                rank_y = rank_y + RANK_BITS'(i_next_y[j] < o_next_y);
            end
        end
    end

    assign o_pick_x = (rank_x == MED_RANK);
    assign o_pick_y = (rank_y == MED_RANK);

endmodule

[hw/rtl/tpq_qualifier.sv]
// Pressure threshold and debounce decision, press state and configuration registers.
module tpq_qualifier
    import tpq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_accept,
    input  logic [PRESSURE_BITS-1:0]  i_pressure,
    input  logic [TIME_BITS-1:0]      i_now_ms,
    output t_qual_ctrl                o_ctrl
);

    logic [CFG_DATA_BITS-1:0] r_threshold, r_debounce;
    logic                     r_pressed, n_pressed;
    logic [TIME_BITS-1:0]     r_last, n_last;
    logic [TIME_BITS-1:0]     elapsed;
    logic                     below, expired;

    assign elapsed = i_now_ms - r_last;
    assign expired = elapsed >= TIME_BITS'(r_debounce);
    assign below   = i_pressure < PRESSURE_BITS'(r_threshold);

    always_comb begin
        n_pressed    = r_pressed;
        n_last       = r_last;
        o_ctrl.shift = !below;
        o_ctrl.touch = 1'b0;
        if (below) begin
            if (r_pressed && expired) begin
                n_pressed = 1'b0;
            end
        end else if (r_pressed || expired) begin
            n_pressed    = 1'b1;
            n_last       = i_now_ms;
            o_ctrl.touch = 1'b1;
        end
        o_ctrl.held = n_pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_debounce  <= DEBOUNCE_RESET;
            r_pressed   <= 1'b0;
            r_last      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PRESSURE_THRESHOLD: r_threshold <= i_cfg_data;
                    CFG_DEBOUNCE_TIME:      r_debounce  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_pressed <= n_pressed;
                r_last    <= n_last;
            end
        end
    end

endmodule

[hw/rtl/touch_press_qualifier_median.sv]
// Top level of the touch press qualifier: window cell chain, median pick, output register.
//
//   channel   direction  handshake                    payload
//   ------    ---------  ---------------------------  -------------------------------------
//   in        input      i_in_valid / o_in_ready      i_raw_x i_raw_y i_pressure i_now_ms
//   out       output     o_out_valid / i_out_ready    o_touch_valid o_point_x o_point_y o_held
//   cfg       input      i_cfg_we (no handshake)      i_cfg_index i_cfg_data
//
// One transaction per cycle while the output is not stalled; every accepted transaction yields
// its result in the output register in the following cycle. The median decision (WINDOW x
// (WINDOW-1) compare ranks in the cells) and the press qualifier settle in the cycle the
// sample is accepted and land in the output register. Synchronous active-low reset returns
// the window to mid scale and clears the press state. A stalled output holds its register;
// input is taken whenever that register is empty or being drained in the same cycle.
module touch_press_qualifier_median
    import tpq_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // input samples
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [SAMPLE_BITS-1:0]    i_raw_x,
    input  logic [SAMPLE_BITS-1:0]    i_raw_y,
    input  logic [PRESSURE_BITS-1:0]  i_pressure,
    input  logic [TIME_BITS-1:0]      i_now_ms,
    // results
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_touch_valid,
    output logic [POINT_BITS-1:0]     o_point_x,
    output logic [POINT_BITS-1:0]     o_point_y,
    output logic                      o_held
);

    logic       accept;
    t_qual_ctrl ctrl;
    logic       shift;

    logic [WINDOW-1:0][SAMPLE_BITS-1:0] cur_x, cur_y, next_x, next_y;
    logic [WINDOW-1:0]                  pick_x, pick_y;
    logic [SAMPLE_BITS-1:0]             med_x, med_y;
    logic [POINT_BITS+SAMPLE_BITS-1:0]  wide_x, wide_y;

    logic                  r_out_valid;
    logic                  r_touch_valid;
    logic                  r_held;
    logic [POINT_BITS-1:0] r_point_x, r_point_y;

    // Take a new transaction when the output register is free or drains now.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    tpq_qualifier u_qual (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pressure  (i_pressure),
        .i_now_ms    (i_now_ms),
        .o_ctrl      (ctrl)
    );

    // Only accepted samples at or above threshold enter the windows. The median is
    // order independent, so the write slot becomes a shift: the newest sample enters
    // cell 0 and the oldest falls out of the last cell.
    assign shift = accept && ctrl.shift;

    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        logic [SAMPLE_BITS-1:0] feed_x, feed_y;
        if (k == 0) begin : g_head
            assign feed_x = i_raw_x;
            assign feed_y = i_raw_y;
        end else begin : g_link
            assign feed_x = cur_x[k-1];
            assign feed_y = cur_y[k-1];
        end

        tpq_cell #(
            .WINDOW      (WINDOW),
            .SAMPLE_BITS (SAMPLE_BITS),
            .INDEX       (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (shift),
            .i_data_x (feed_x),
            .i_data_y (feed_y),
            .i_next_x (next_x),
            .i_next_y (next_y),
            .o_x      (cur_x[k]),
            .o_y      (cur_y[k]),
            .o_next_x (next_x[k]),
            .o_next_y (next_y[k]),
            .o_pick_x (pick_x[k]),
            .o_pick_y (pick_y[k])
        );
    end

    // Exactly one cell holds the middle rank in each window; merge its value.
    always_comb begin
        med_x = '0;
        med_y = '0;
        for (int k = 0; k < WINDOW; k++) begin
            med_x = med_x | (pick_x[k] ? next_x[k] : '0);
            med_y = med_y | (pick_y[k] ? next_y[k] : '0);
        end
    end

    // Fit the median to the fixed point width.
    assign wide_x = {{POINT_BITS{1'b0}}, med_x};
    assign wide_y = {{POINT_BITS{1'b0}}, med_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: point is zero unless a press is reported.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_touch_valid <= ctrl.touch;
            r_held        <= ctrl.held;
            r_point_x     <= ctrl.touch ? wide_x[POINT_BITS-1:0] : '0;
            r_point_y     <= ctrl.touch ? wide_y[POINT_BITS-1:0] : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_touch_valid = r_touch_valid;
    assign o_point_x     = r_point_x;
    assign o_point_y     = r_point_y;
    assign o_held        = r_held;

endmodule
